// ===== rtl/wcm_pkg.sv =====
// Shared types and constants for the wall column texture mapper.
// No dependencies; imported by wcm_muldiv and wall_column_texture_mapper.
package wcm_pkg;

    typedef enum logic [1:0] {
        UNIT_DIV = 2'b01,
        UNIT_MUL = 2'b10
    } wcm_unit_op_t;

    typedef struct packed {
        logic         start;
        wcm_unit_op_t op;
    } wcm_unit_req_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_STEP = 6'b000010,
        S_EYE  = 6'b000100,
        S_MUL  = 6'b001000,
        S_ROW  = 6'b010000,
        S_FIN  = 6'b100000
    } wcm_state_t;

    typedef enum logic [2:0] {
        REG_TEX_WIDTH_LOG2  = 3'd0,
        REG_TEX_HEIGHT_LOG2 = 3'd1,
        REG_SCREEN_HEIGHT   = 3'd2,
        REG_PITCH_OFFSET    = 3'd3,
        REG_EYE_HEIGHT      = 3'd4
    } wcm_reg_idx_t;

    localparam int UNIT_W      = 32;
    localparam int HIT_SCALE_LOG2 = 10;
    localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;

endpackage

// ===== rtl/wcm_muldiv.sv =====
// Shared iterative unit: restoring divide or shift-add multiply, one bit a cycle.
// Depends on wcm_pkg. One 34-bit adder serves both operations.
module wcm_muldiv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wcm_pkg::wcm_unit_req_t req,
    input  logic [31:0]           a,
    input  logic [31:0]           b,
    output logic                  done,
    output logic [63:0]           result
);
    import wcm_pkg::*;

    logic [31:0]  hi_reg, hi_next;
    logic [31:0]  lo_reg, lo_next;
    logic [31:0]  a_reg;
    logic [31:0]  b_reg;
    wcm_unit_op_t op_reg;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    logic [33:0]  add_x, add_y, add_sum;
    logic         is_div;

    assign is_div = (op_reg == UNIT_DIV);

    // shared adder
    always_comb
    begin
        if (is_div)
        begin
            add_x = {1'b0, hi_reg, lo_reg[31]};
            add_y = ~{2'b00, b_reg};
            add_sum = add_x + add_y + 34'd1;
        end
        else
        begin
            add_x = {2'b00, hi_reg};
            add_y = {2'b00, lo_reg[0] ? a_reg : 32'd0};
            add_sum = add_x + add_y;
        end
    end

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                if (!add_sum[33])
                begin
                    hi_next = add_sum[31:0];
                    lo_next = {lo_reg[30:0], 1'b1};
                end
                else
                begin
                    hi_next = {hi_reg[30:0], lo_reg[31]};
                    lo_next = {lo_reg[30:0], 1'b0};
                end
            end
            else
            begin
                hi_next = add_sum[32:1];
                lo_next = {add_sum[0], lo_reg[31:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(UNIT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // divide loads the dividend into lo, multiply the multiplier
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg <= req.op;
            if (req.op == UNIT_DIV)
            begin
                a_reg <= b;
                b_reg <= b;
            end
            else
            begin
                a_reg <= a;
                b_reg <= b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= (req.start && req.op == UNIT_DIV) ? 32'd0 : hi_next;
        lo_reg <= (req.start && req.op == UNIT_DIV) ? a : lo_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = is_div ? {32'd0, lo_reg} : {hi_reg, lo_reg};
endmodule

// ===== rtl/wcm_tex_mem.sv =====
// Texel memory: one write port, one registered read port.
// No package dependency.
module wcm_tex_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/wall_column_texture_mapper.sv =====
// Wall column texture mapper: top level with sequencer, config and output register.
// Depends on wcm_pkg, wcm_muldiv and wcm_tex_mem.
//
// Load requests write one texel when face and load_index are in range. A render
// request without new_column goes from accept through S_ROW (address and memory
// read) to S_FIN (output register). A render request with new_column first runs
// the shared 32-step multiply/divide unit three times (texture step, eye
// quotient, start position product), each run being start, 32 steps and done,
// then goes through S_ROW and S_FIN. A pixel still unclaimed when the next
// one is ready holds the sequencer until the output register frees. The block
// accepts one request at a time; the finished pixel waits in the output
// register so the next request is taken while it is unclaimed. Texels never
// loaded read as undefined data.
module wall_column_texture_mapper #(
    parameter int TEX_DIM    = 64,
    parameter int FACE_COUNT = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [20:0]  cfg_wdata,
    // request channel
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         opcode,
    input  logic         new_column,
    input  logic [11:0]  column_x,
    input  logic [11:0]  row_y,
    input  logic [11:0]  slice_top,
    input  logic [15:0]  line_h,
    input  logic [23:0]  perp_dist,
    input  logic [9:0]   hit_x,
    input  logic [1:0]   face,
    input  logic [11:0]  load_index,
    input  logic [31:0]  load_color,
    // pixel channel
    output logic         out_valid,
    input  logic         out_stall,
    output logic [11:0]  pixel_x,
    output logic [11:0]  pixel_y,
    output logic [31:0]  pixel_color
);
    import wcm_pkg::*;

    localparam int TL         = $clog2(TEX_DIM);
    localparam int FACE_WORDS = TEX_DIM * TEX_DIM;
    localparam int DEPTH      = FACE_COUNT * FACE_WORDS;
    localparam int AW         = $clog2(DEPTH);

    // configuration registers
    logic [2:0]  tex_width_log2_reg;
    logic [2:0]  tex_height_log2_reg;
    logic [11:0] screen_height_reg;
    logic [12:0] pitch_offset_reg;
    logic [20:0] eye_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_log2_reg  <= 3'd6;
            tex_height_log2_reg <= 3'd6;
            screen_height_reg   <= 12'd480;
            pitch_offset_reg    <= '0;
            eye_height_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEX_WIDTH_LOG2:  tex_width_log2_reg  <= cfg_wdata[2:0];
                REG_TEX_HEIGHT_LOG2: tex_height_log2_reg <= cfg_wdata[2:0];
                REG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_wdata[11:0];
                REG_PITCH_OFFSET:    pitch_offset_reg    <= cfg_wdata[12:0];
                REG_EYE_HEIGHT:      eye_height_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp log2 sizes to the memory's texture dimension
    logic [3:0] wl, hl;
    assign wl = ({1'b0, tex_width_log2_reg} > 4'(TL)) ? 4'(TL) : {1'b0, tex_width_log2_reg};
    assign hl = ({1'b0, tex_height_log2_reg} > 4'(TL)) ? 4'(TL) : {1'b0, tex_height_log2_reg};

    // sequencer state and held request fields
    wcm_state_t  state_reg, state_next;
    logic        unit_start_reg, unit_start_next;
    logic [11:0] col_reg, row_reg, dstart_reg;
    logic [15:0] lineh_reg;
    logic [23:0] perp_reg;
    logic [9:0]  hit_reg;
    logic [1:0]  face_reg;
    logic [31:0] step_reg, step_next;
    logic [47:0] pos_reg, pos_next;
    logic [31:0] base_reg, base_next;
    logic        out_valid_reg, out_valid_next;
    logic [11:0] pixel_x_reg, pixel_y_reg;
    logic [31:0] pixel_color_reg;
    logic        face_ok_reg;

    logic in_accept, out_take;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // load path: write straight into texel memory on accept, when face and index are in range
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    assign mem_we = in_accept && (opcode == 1'b0) && (32'(face) < 32'(FACE_COUNT))
                 && (32'(load_index) < 32'(FACE_WORDS));
    assign mem_waddr = AW'((32'(face) << (2 * TL)) | 32'(load_index));

    // shared unit operands, chosen by state
    wcm_unit_req_t unit_req;
    logic [31:0]   unit_a, unit_b;
    logic          unit_done;
    logic [63:0]   unit_result;

    logic        eye_neg;
    logic [20:0] eye_mag;
    logic [23:0] perp_nz;
    logic        base_neg;
    logic [31:0] base_mag;

    assign eye_neg  = eye_height_reg[20];
    assign eye_mag  = eye_neg ? (~eye_height_reg + 21'd1) : eye_height_reg;
    assign perp_nz  = (perp_reg == 24'd0) ? 24'd1 : perp_reg;
    assign base_neg = base_reg[31];
    assign base_mag = base_neg ? (~base_reg + 32'd1) : base_reg;

    always_comb
    begin
        unit_req.start = unit_start_reg;
        unit_req.op    = (state_reg == S_MUL) ? UNIT_MUL : UNIT_DIV;
        unit_a = '0;
        unit_b = '0;
        unique case (state_reg)
            S_STEP:
            begin
                unit_a = (32'd1 << hl) << 16;
                unit_b = {16'd0, lineh_reg};
            end
            S_EYE:
            begin
                unit_a = {3'd0, eye_mag, 8'd0};
                unit_b = {8'd0, perp_nz};
            end
            S_MUL:
            begin
                unit_a = base_mag;
                unit_b = step_reg;
            end
            default: ;
        endcase
    end

    wcm_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (unit_req),
        .a      (unit_a),
        .b      (unit_b),
        .done   (unit_done),
        .result (unit_result)
    );

    // start position base from the eye quotient
    logic [31:0] quot_s;
    logic [31:0] base_calc;
    assign quot_s = eye_neg ? (~unit_result[31:0] + 32'd1) : unit_result[31:0];
    assign base_calc = {20'd0, dstart_reg} - {{19{pitch_offset_reg[12]}}, pitch_offset_reg}
                     - quot_s - {21'd0, screen_height_reg[11:1]} + {17'd0, lineh_reg[15:1]};

    // saturate the start product to signed 48 bits
    logic [47:0] pos_start;
    always_comb
    begin
        if (base_neg)
        begin
            if (unit_result > 64'h0000_8000_0000_0000)
                pos_start = POS_MIN;
            else
                pos_start = ~unit_result[47:0] + 48'd1;
        end
        else
        begin
            if (unit_result > {16'd0, POS_MAX})
                pos_start = POS_MAX;
            else
                pos_start = unit_result[47:0];
        end
    end

    // row lookup: texel row truncated toward zero, column from hit
    logic          pos_neg;
    logic [47:0]   pos_mag;
    logic [TL-1:0] ip_low, ty, tx;
    logic [19:0]   hit_scaled;
    logic [48:0]   pos_sum;
    logic [AW-1:0] mem_raddr;
    logic          mem_re;

    assign pos_neg    = pos_reg[47];
    assign pos_mag    = pos_neg ? (~pos_reg + 48'd1) : pos_reg;
    assign ip_low     = pos_mag[16 +: TL];
    assign ty         = (pos_neg ? (~ip_low + TL'(1)) : ip_low)
                      & TL'((32'd1 << hl) - 32'd1);
    assign hit_scaled = 20'({10'd0, hit_reg} << wl) >> HIT_SCALE_LOG2;
    assign tx         = hit_scaled[TL-1:0] & TL'((32'd1 << wl) - 32'd1);
    assign pos_sum    = {pos_reg[47], pos_reg} + {17'd0, step_reg};
    assign mem_re     = (state_reg == S_ROW);
    assign mem_raddr  = AW'((32'(face_reg) << (2 * TL))
                      | (32'(ty) << wl) | 32'(tx));

    logic [31:0] mem_rdata;

    wcm_tex_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_tex_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (load_color),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        unit_start_next = 1'b0;
        step_next       = step_reg;
        pos_next        = pos_reg;
        base_next       = base_reg;
        out_valid_next  = out_take ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && opcode)
                begin
                    if (new_column)
                    begin
                        state_next      = S_STEP;
                        unit_start_next = 1'b1;
                    end
                    else
                        state_next = S_ROW;
                end
            end
            S_STEP:
            begin
                if (unit_done)
                begin
                    step_next       = (lineh_reg == 16'd0) ? 32'hFFFF_FFFF : unit_result[31:0];
                    state_next      = S_EYE;
                    unit_start_next = 1'b1;
                end
            end
            S_EYE:
            begin
                if (unit_done)
                begin
                    base_next       = base_calc;
                    state_next      = S_MUL;
                    unit_start_next = 1'b1;
                end
            end
            S_MUL:
            begin
                if (unit_done)
                begin
                    pos_next   = pos_start;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                // advance position, saturating upward
                if (!pos_sum[48] && pos_sum[47])
                    pos_next = POS_MAX;
                else
                    pos_next = pos_sum[47:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_stall == 1'b0)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            unit_start_reg <= 1'b0;
            step_reg       <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            unit_start_reg <= unit_start_next;
            step_reg       <= step_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold request fields and load the pixel register
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        if (in_accept)
        begin
            col_reg     <= column_x;
            row_reg     <= row_y;
            dstart_reg  <= slice_top;
            lineh_reg   <= line_h;
            perp_reg    <= perp_dist;
            hit_reg     <= hit_x;
            face_reg    <= face;
            face_ok_reg <= (32'(face) < 32'(FACE_COUNT));
        end
        if (state_reg == S_FIN && (!out_valid_reg || !out_stall))
        begin
            pixel_x_reg     <= col_reg;
            pixel_y_reg     <= row_reg;
            pixel_color_reg <= face_ok_reg ? mem_rdata : 32'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
endmodule
